/* hw/rtl/tdq_pkg.sv */
// Shared types, constants and helper functions of the timer queue.
package tdq_pkg;

  localparam int FUNC_W = 2;
  localparam int KIND_W = 2;
  localparam int ID_W   = 4;
  localparam int IVL_W  = 32;
  localparam int MS_W   = 32;
  localparam int TIME_W = 48;

  localparam int MAX_IDS        = 1 << ID_W;
  localparam int NUM_TIMERS_DEF = 16;

  // One hour in ms.
  localparam logic [MS_W-1:0]   IDLE_RESET_MS = MS_W'(3600 * 1000);
  localparam logic [TIME_W-1:0] TIME_LIMIT    = {TIME_W{1'b1}};

  typedef enum logic [FUNC_W-1:0] {
    FN_START = 2'd0,
    FN_STOP  = 2'd1,
    FN_TICK  = 2'd2,
    FN_QUERY = 2'd3
  } func_t;

  typedef enum logic [KIND_W-1:0] {
    KD_STATUS = 2'd0,
    KD_FIRE   = 2'd1,
    KD_QUERY  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_POP,
    CELL_MARK
  } cell_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REMOVE,
    ST_INSERT,
    ST_MARK,
    ST_POP,
    ST_REINS,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic              valid;
    logic              due;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] dl;
  } cell_entry_t;

  typedef struct packed {
    cell_op_t          op;
    logic [TIME_W-1:0] key_dl;
    logic [ID_W-1:0]   key_id;
    logic [TIME_W-1:0] now;
  } cell_cmd_t;

  function automatic logic [TIME_W-1:0] add_sat(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? TIME_LIMIT : s[TIME_W-1:0];
  endfunction

  // ms from now until when, floored at 0 and clipped to 32 bits
  function automatic logic [MS_W-1:0] until_ms(input logic [TIME_W-1:0] when,
                                               input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] d;
    logic [MS_W-1:0]   res;
    d = when - now;
    if (when <= now) begin
      res = '0;
    end else if (d[TIME_W-1:MS_W] != '0) begin
      res = {MS_W{1'b1}};
    end else begin
      res = d[MS_W-1:0];
    end
    return res;
  endfunction

endpackage

/* hw/rtl/deadline_ordered_timer_queue.sv */
// Top level: deadline-sorted timer queue with a ms time base and command control.
// Query answers directly; stop removes the timer first if armed; start inserts, after
// a remove if the timer was armed; tick marks due entries, then pops each due head
// and re-arms repeating ones; a new item is taken in the cycle the last word is out.
// Fire words leave one per pop of the cell row; a repeating fire adds an insert pass.
// Reset is synchronous and leaves the queue empty at once; results cannot be stalled.
module deadline_ordered_timer_queue import tdq_pkg::*; #(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // command side
  input  logic              start,
  output logic              busy,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [ID_W-1:0]   in_timer_id,
  input  logic [IVL_W-1:0]  in_interval_ms,
  input  logic              in_repeat_req,
  // configuration: idle timeout
  input  logic              cfg_we,
  input  logic [MS_W-1:0]   cfg_wdata,
  // result side, one word per strobe
  output logic              out_strobe,
  output logic [KIND_W-1:0] out_kind,
  output logic [ID_W-1:0]   out_fired_id,
  output logic [MS_W-1:0]   out_remaining_ms,
  output logic [MS_W-1:0]   out_next_ms,
  output logic              out_became_first,
  output logic              out_timer_active,
  output logic              out_last
);

  // Only ids below both NUM_TIMERS and the id range get a slot.
  localparam int SLOTS  = (NUM_TIMERS < MAX_IDS) ? NUM_TIMERS : MAX_IDS;
  localparam int SLOT_W = $clog2(SLOTS);

  // ---------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------
  state_t            state_r, state_nxt;
  func_t             func_r;
  logic [ID_W-1:0]   id_r;
  logic              id_ok_r;
  logic [TIME_W-1:0] key_dl_r;
  logic [ID_W-1:0]   key_id_r;
  logic [TIME_W-1:0] now_r;
  logic [MS_W-1:0]   idle_r;

  // per-timer flags (reset) and per-timer values (written before read)
  logic [SLOTS-1:0]  armed_r;
  logic [SLOTS-1:0]  rep_r;
  logic [TIME_W-1:0] dl_mem     [SLOTS];
  logic [IVL_W-1:0]  period_mem [SLOTS];

  // output word
  logic              out_strobe_r, strobe_nxt;
  kind_t             out_kind_r;
  logic [ID_W-1:0]   out_id_r;
  logic [MS_W-1:0]   out_rem_r;
  logic [MS_W-1:0]   out_next_r;
  logic              out_bf_r;
  logic              out_act_r;
  logic              out_last_r;

  cell_cmd_t         cmd;
  cell_entry_t       head;

  // ---------------------------------------------------------------------
  // Decode
  // ---------------------------------------------------------------------
  logic              accept;
  func_t             in_fn;
  logic              in_id_ok;
  logic [SLOT_W-1:0] acc_idx, item_idx, head_idx;
  logic [TIME_W-1:0] acc_dl, rearm_dl;
  logic              head_due;
  logic              item_armed;

  assign in_fn      = func_t'(in_func);
  assign accept     = start && !busy;
  assign in_id_ok   = int'(in_timer_id) < NUM_TIMERS;
  assign acc_idx    = in_timer_id[SLOT_W-1:0];
  assign item_idx   = id_r[SLOT_W-1:0];
  assign head_idx   = head.id[SLOT_W-1:0];
  assign acc_dl     = add_sat(now_r, {{(TIME_W-IVL_W){1'b0}}, in_interval_ms});
  assign rearm_dl   = add_sat(now_r, {{(TIME_W-IVL_W){1'b0}}, period_mem[head_idx]});
  assign head_due   = head.valid && head.due;
  assign item_armed = id_ok_r && armed_r[item_idx];

  // ---------------------------------------------------------------------
  // Control: next state and the command for the cell row
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt  = state_r;
    strobe_nxt = 1'b0;
    cmd.op     = CELL_HOLD;
    cmd.key_dl = key_dl_r;
    cmd.key_id = key_id_r;
    cmd.now    = now_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_fn)
            FN_START: begin
              if (!in_id_ok) begin
                state_nxt = ST_RESP;
              end else if (armed_r[acc_idx]) begin
                state_nxt = ST_REMOVE;
              end else begin
                state_nxt = ST_INSERT;
              end
            end
            FN_STOP: begin
              state_nxt = (in_id_ok && armed_r[acc_idx]) ? ST_REMOVE : ST_RESP;
            end
            FN_TICK:  state_nxt = ST_MARK;
            default:  state_nxt = ST_RESP;
          endcase
        end
      end
      ST_REMOVE: begin
        cmd.op    = CELL_REMOVE;
        state_nxt = (func_r == FN_START) ? ST_INSERT : ST_RESP;
      end
      ST_INSERT: begin
        cmd.op    = CELL_INSERT;
        state_nxt = ST_RESP;
      end
      ST_MARK: begin
        // flag every entry already expired at the new time
        cmd.op    = CELL_MARK;
        state_nxt = ST_POP;
      end
      ST_POP: begin
        if (head_due) begin
          cmd.op     = CELL_POP;
          strobe_nxt = 1'b1;
          if (rep_r[head_idx]) begin
            state_nxt = ST_REINS;
          end
        end else begin
          state_nxt = ST_RESP;
        end
      end
      ST_REINS: begin
        cmd.op    = CELL_INSERT;
        state_nxt = ST_POP;
      end
      ST_RESP: begin
        strobe_nxt = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Control registers: time base, per-timer flags, config, strobe
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r        <= '0;
      armed_r      <= '0;
      rep_r        <= '0;
      idle_r       <= IDLE_RESET_MS;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= strobe_nxt;
      if (cfg_we) begin
        idle_r <= cfg_wdata;
      end
      if (accept) begin
        case (in_fn)
          FN_START: begin
            if (in_id_ok) begin
              armed_r[acc_idx] <= 1'b1;
              rep_r[acc_idx]   <= in_repeat_req;
            end
          end
          FN_STOP: begin
            if (in_id_ok) begin
              armed_r[acc_idx] <= 1'b0;
            end
          end
          FN_TICK:  now_r <= add_sat(now_r, TIME_W'(1));
          default: begin
          end
        endcase
      end
      // a one-shot timer is done once it fires
      if (state_r == ST_POP && head_due && !rep_r[head_idx]) begin
        armed_r[head_idx] <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Item registers and per-timer values
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r   <= in_fn;
      id_r     <= in_timer_id;
      id_ok_r  <= in_id_ok;
      key_id_r <= in_timer_id;
      key_dl_r <= acc_dl;
      if (in_fn == FN_START && in_id_ok) begin
        period_mem[acc_idx] <= in_interval_ms;
        dl_mem[acc_idx]     <= acc_dl;
      end
    end
    if (state_r == ST_POP && head_due && rep_r[head_idx]) begin
      key_id_r         <= head.id;
      key_dl_r         <= rearm_dl;
      dl_mem[head_idx] <= rearm_dl;
    end
  end

  // ---------------------------------------------------------------------
  // Output word
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state_r == ST_POP && head_due) begin
      out_kind_r <= KD_FIRE;
      out_id_r   <= head.id;
      out_rem_r  <= '0;
      out_next_r <= '0;
      out_bf_r   <= 1'b0;
      out_act_r  <= rep_r[head_idx];
      out_last_r <= 1'b0;
    end else if (state_r == ST_RESP) begin
      out_kind_r <= (func_r == FN_QUERY) ? KD_QUERY : KD_STATUS;
      out_id_r   <= (func_r == FN_TICK) ? '0 : id_r;
      out_rem_r  <= (func_r == FN_QUERY && item_armed) ?
                    until_ms(dl_mem[item_idx], now_r) : '0;
      out_next_r <= head.valid ? until_ms(head.dl, now_r) : idle_r;
      out_bf_r   <= (func_r == FN_START) && id_ok_r && head.valid && (head.id == id_r);
      out_act_r  <= ((func_r == FN_START) && id_ok_r) ||
                    ((func_r == FN_QUERY) && item_armed);
      out_last_r <= 1'b1;
    end
  end

  tdq_chain #(
    .DEPTH(SLOTS)
  ) u_chain (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cmd),
    .head (head)
  );

  assign busy             = (state_r != ST_IDLE);
  assign out_strobe       = out_strobe_r;
  assign out_kind         = out_kind_r;
  assign out_fired_id     = out_id_r;
  assign out_remaining_ms = out_rem_r;
  assign out_next_ms      = out_next_r;
  assign out_became_first = out_bf_r;
  assign out_timer_active = out_act_r;
  assign out_last         = out_last_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not make the block busy");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last |-> !busy)
    else $error("final result word while still busy");

  a_fire_mid_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_kind == KD_FIRE) |-> busy && !out_last)
    else $error("fire word outside a tick");

  a_first_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_became_first |-> out_timer_active)
    else $error("became_first on an inactive timer");

endmodule

/* hw/rtl/tdq_cell.sv */
// One slot of the sorted queue: holds one entry, shifts to and from its neighbors.
module tdq_cell import tdq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cell_cmd_t   cmd,
  input  cell_entry_t left_entry,
  input  cell_entry_t right_entry,
  input  logic        left_ge,
  input  logic        left_seen,
  output cell_entry_t entry,
  output logic        ge,
  output logic        seen
);

  logic              valid_r, valid_nxt;
  logic              due_r, due_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [TIME_W-1:0] dl_r, dl_nxt;
  logic              match;

  always_comb begin
    // due entries always sort ahead of the key for an insert
    ge    = !valid_r || (!due_r && (dl_r >= cmd.key_dl));
    match = valid_r && (id_r == cmd.key_id);
    seen  = left_seen || match;

    valid_nxt = valid_r;
    due_nxt   = due_r;
    id_nxt    = id_r;
    dl_nxt    = dl_r;
    case (cmd.op)
      CELL_INSERT: begin
        if (left_ge) begin
          valid_nxt = left_entry.valid;
          due_nxt   = left_entry.due;
          id_nxt    = left_entry.id;
          dl_nxt    = left_entry.dl;
        end else if (ge) begin
          valid_nxt = 1'b1;
          due_nxt   = 1'b0;
          id_nxt    = cmd.key_id;
          dl_nxt    = cmd.key_dl;
        end
      end
      CELL_REMOVE: begin
        if (seen) begin
          valid_nxt = right_entry.valid;
          due_nxt   = right_entry.due;
          id_nxt    = right_entry.id;
          dl_nxt    = right_entry.dl;
        end
      end
      CELL_POP: begin
        valid_nxt = right_entry.valid;
        due_nxt   = right_entry.due;
        id_nxt    = right_entry.id;
        dl_nxt    = right_entry.dl;
      end
      CELL_MARK: begin
        due_nxt = valid_r && (dl_r <= cmd.now);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      due_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      due_r   <= due_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
    dl_r <= dl_nxt;
  end

  assign entry = '{valid: valid_r, due: due_r, id: id_r, dl: dl_r};

endmodule

/* hw/rtl/tdq_chain.sv */
// Row of queue cells, kept sorted by deadline with the earliest at cell 0.
module tdq_chain import tdq_pkg::*; #(
  parameter int DEPTH = NUM_TIMERS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cell_cmd_t   cmd,
  output cell_entry_t head
);

  cell_entry_t      ent [DEPTH];
  logic [DEPTH-1:0] ge_v;
  logic [DEPTH-1:0] seen_v;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_entry_t lf_e, rt_e;
    logic        lf_ge, lf_seen;

    if (i == 0) begin : g_first
      assign lf_e    = '0;
      assign lf_ge   = 1'b0;
      assign lf_seen = 1'b0;
    end else begin : g_inner
      assign lf_e    = ent[i-1];
      assign lf_ge   = ge_v[i-1];
      assign lf_seen = seen_v[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rt_e = '0;
    end else begin : g_link
      assign rt_e = ent[i+1];
    end

    tdq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .left_entry (lf_e),
      .right_entry(rt_e),
      .left_ge    (lf_ge),
      .left_seen  (lf_seen),
      .entry      (ent[i]),
      .ge         (ge_v[i]),
      .seen       (seen_v[i])
    );
  end

  assign head = ent[0];

endmodule
